// File: rtl/core/cmas_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
package cmas_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int MAP_BLOCKS_DEF      = 4096;
	localparam int MAX_DIR_ENTRIES_DEF = 2048;

	// The used-block map is stored as rows of this many bits.
	localparam int ROW_BITS   = 8;
	localparam int ROW_SEL_W  = 3;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_BLOCK     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_DIR_ENTRY = 2'd2;

	// Configuration reset values.
	localparam logic [11:0] LAST_BLOCK_RST     = 12'd194;
	localparam logic [2:0]  BLOCK_SHIFT_RST    = 3'd4;
	localparam logic [10:0] LAST_DIR_ENTRY_RST = 11'd63;

	// Directory entry layout.
	localparam logic [4:0] POS_USER      = 5'd0;
	localparam logic [4:0] POS_EXT_LO    = 5'd12;
	localparam logic [4:0] POS_EXT_HI    = 5'd14;
	localparam logic [4:0] POS_ALLOC     = 5'd16;
	localparam logic [4:0] POS_LAST      = 5'd31;
	localparam logic [7:0] USER_MAX      = 8'd31;
	localparam logic [7:0] EXT_HI_MASK   = 8'h3F;
	localparam logic [11:0] SHORT_BLK_MAX = 12'd255;

	// Minimum block size is 128 bytes.
	localparam int BLOCK_BASE_SHIFT = 7;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic update;
		logic report;
		logic clear;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic final_byte;
		logic clear_last;
	} dp_status_t;

endpackage

// File: rtl/core/cmas_ctrl.sv
// Controller state machine for the directory allocation statistics block.
module cmas_ctrl
	import cmas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output ctl_cmd_t   cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_REPORT = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = status.final_byte ? ST_REPORT : ST_IDLE;
			end
			ST_REPORT: begin
				state_d = ST_CLEAR;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// State register and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_REPORT);
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && start;
		cmd.update = (state_q == ST_UPDATE);
		cmd.report = (state_q == ST_REPORT);
		cmd.clear  = (state_q == ST_CLEAR);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

// File: rtl/core/cmas_datapath.sv
// Datapath: configuration registers, entry decode, used-block map and counters.
module cmas_datapath
	import cmas_pkg::*;
#(
	parameter int MAP_BLOCKS      = MAP_BLOCKS_DEF,
	parameter int MAX_DIR_ENTRIES = MAX_DIR_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_status_t            status,
	input  logic [7:0]            dir_byte,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [11:0]           files_total,
	output logic [11:0]           entries_used,
	output logic [12:0]           used_blk_cnt,
	output logic [12:0]           free_blk_cnt,
	output logic [12:0]           disk_blk_cnt,
	output logic [14:0]           block_bytes,
	output logic [26:0]           free_byte_cnt
);

	localparam int BLK_W  = $clog2(MAP_BLOCKS);
	localparam int ROW_AW = BLK_W - ROW_SEL_W;
	localparam int ROWS   = MAP_BLOCKS / ROW_BITS;
	localparam int IDX_W  = $clog2(MAX_DIR_ENTRIES);

	// Configuration registers.
	logic [11:0] last_block_q;
	logic [2:0]  block_shift_q;
	logic [10:0] last_dir_entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_block_q     <= LAST_BLOCK_RST;
			block_shift_q    <= BLOCK_SHIFT_RST;
			last_dir_entry_q <= LAST_DIR_ENTRY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LAST_BLOCK:     last_block_q     <= cfg_data;
				CFG_BLOCK_SHIFT:    block_shift_q    <= cfg_data[2:0];
				CFG_LAST_DIR_ENTRY: last_dir_entry_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// Run state.
	logic [4:0]       byte_pos_q;
	logic [IDX_W-1:0] entry_idx_q;
	logic             entry_valid_q;
	logic             ext_zero_q;
	logic [7:0]       low_hold_q;
	logic [11:0]      files_q;
	logic [11:0]      valid_q;
	logic [12:0]      used_q;
	logic [ROW_AW-1:0] clr_addr_q;

	// Stage registers between request accept and the map update.
	logic             mark_s1;
	logic [BLK_W-1:0] blk_s1;
	logic             final_s1;
	logic [ROW_BITS-1:0] row_rd_s1;

	// Used-block map, one row of bits per address.
	logic [ROW_BITS-1:0] map_mem [ROWS];

	// Block number decode for the incoming byte.
	logic        wide;
	logic [15:0] blk16;
	logic        alloc_slot;
	logic        in_range;
	logic [IDX_W-1:0] final_idx;
	logic        more_entries;

	always_comb begin
		wide       = (last_block_q > SHORT_BLK_MAX);
		blk16      = wide ? {dir_byte, low_hold_q} : {8'd0, dir_byte};
		alloc_slot = (byte_pos_q >= POS_ALLOC) && entry_valid_q && (!wide || byte_pos_q[0]);
		in_range   = (blk16 != 16'd0) && (blk16 <= {4'd0, last_block_q})
			&& (32'(blk16) < MAP_BLOCKS);
		final_idx  = (32'(last_dir_entry_q) >= MAX_DIR_ENTRIES)
			? IDX_W'(MAX_DIR_ENTRIES - 1) : IDX_W'(last_dir_entry_q);
		more_entries = (entry_idx_q < final_idx);
	end

	// Map read on accept; the row is registered for the update cycle.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_rd_s1 <= map_mem[blk16[BLK_W-1:ROW_SEL_W]];
			blk_s1    <= blk16[BLK_W-1:0];
		end
	end

	// Map write: clearing sweep, or setting a newly used bit.
	logic [ROW_BITS-1:0] bit_sel;
	logic                newly_used;

	always_comb begin
		bit_sel    = ROW_BITS'(1) << blk_s1[ROW_SEL_W-1:0];
		newly_used = cmd.update && mark_s1 && ((row_rd_s1 & bit_sel) == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			map_mem[clr_addr_q] <= '0;
		end else if (newly_used) begin
			map_mem[blk_s1[BLK_W-1:ROW_SEL_W]] <= row_rd_s1 | bit_sel;
		end
	end

	// Summary arithmetic.
	logic [12:0] total_w;
	logic [12:0] free_w;

	always_comb begin
		total_w = 13'(last_block_q) + 13'd1;
		free_w  = (used_q >= total_w) ? 13'd0 : total_w - used_q;
	end

	// Result registers, loaded in the report cycle.
	always_ff @(posedge clk) begin
		if (cmd.report) begin
			files_total   <= files_q;
			entries_used  <= valid_q;
			used_blk_cnt  <= used_q;
			free_blk_cnt  <= free_w;
			disk_blk_cnt  <= total_w;
			block_bytes   <= 15'(15'd1 << (BLOCK_BASE_SHIFT + int'(block_shift_q)));
			free_byte_cnt <= 27'(27'(free_w) << (BLOCK_BASE_SHIFT + int'(block_shift_q)));
		end
	end

	// Entry decode, counters and run position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q    <= '0;
			entry_idx_q   <= '0;
			entry_valid_q <= 1'b0;
			ext_zero_q    <= 1'b1;
			low_hold_q    <= '0;
			files_q       <= '0;
			valid_q       <= '0;
			used_q        <= '0;
			clr_addr_q    <= '0;
			mark_s1       <= 1'b0;
			final_s1      <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end

			if (newly_used) begin
				used_q <= used_q + 13'd1;
			end

			if (cmd.accept) begin
				mark_s1  <= alloc_slot && in_range;
				final_s1 <= (byte_pos_q == POS_LAST) && !more_entries;

				// Field decode by position within the entry.
				if (byte_pos_q == POS_USER) begin
					entry_valid_q <= (dir_byte <= USER_MAX);
				end else if (byte_pos_q == POS_EXT_LO) begin
					ext_zero_q <= (dir_byte == 8'd0);
				end else if (byte_pos_q == POS_EXT_HI) begin
					if ((dir_byte & EXT_HI_MASK) != 8'd0) ext_zero_q <= 1'b0;
				end else if (byte_pos_q >= POS_ALLOC && wide && !byte_pos_q[0]) begin
					low_hold_q <= dir_byte;
				end

				// Entry close: count it and advance to the next entry.
				if (byte_pos_q == POS_LAST) begin
					byte_pos_q    <= '0;
					entry_valid_q <= 1'b0;
					ext_zero_q    <= 1'b1;
					if (entry_valid_q) begin
						valid_q <= valid_q + 12'd1;
						if (ext_zero_q) files_q <= files_q + 12'd1;
					end
					if (more_entries) entry_idx_q <= entry_idx_q + 1'b1;
				end else begin
					byte_pos_q <= byte_pos_q + 5'd1;
				end
			end

			// After the summary the run starts over.
			if (cmd.report) begin
				byte_pos_q    <= '0;
				entry_idx_q   <= '0;
				entry_valid_q <= 1'b0;
				ext_zero_q    <= 1'b1;
				low_hold_q    <= '0;
				files_q       <= '0;
				valid_q       <= '0;
				used_q        <= '0;
				clr_addr_q    <= '0;
				final_s1      <= 1'b0;
			end
		end
	end

	// Status to the controller.
	always_comb begin
		status.final_byte = final_s1;
		status.clear_last = (clr_addr_q == ROW_AW'(ROWS - 1));
	end

endmodule

// File: rtl/core/cpm_allocation_map_stats.sv
// Top level of the directory allocation statistics block.
//
//   channel   direction  handshake                 payload
//   request   in         start && !busy            dir_byte
//   config    in         cfg_valid && cfg_ready    cfg_index, cfg_data
//   result    out        done (one-cycle strobe)   files_total .. free_byte_cnt
//
// For each directory byte, the accept cycle reads the map row and
// the next cycle writes it back through the single map port, before a new byte is taken.
// The final byte of the last entry adds a report state; done follows it.
// After reset and after every result a clearing pass sweeps the map row by row, with busy high.
// Results cannot be stalled; configuration writes are taken at any time.
module cpm_allocation_map_stats
	import cmas_pkg::*;
#(
	parameter int MAP_BLOCKS      = MAP_BLOCKS_DEF,
	parameter int MAX_DIR_ENTRIES = MAX_DIR_ENTRIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [7:0]            dir_byte,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [11:0]           files_total,
	output logic [11:0]           entries_used,
	output logic [12:0]           used_blk_cnt,
	output logic [12:0]           free_blk_cnt,
	output logic [12:0]           disk_blk_cnt,
	output logic [14:0]           block_bytes,
	output logic [26:0]           free_byte_cnt
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	// Controller.
	cmas_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath.
	cmas_datapath #(
		.MAP_BLOCKS      (MAP_BLOCKS),
		.MAX_DIR_ENTRIES (MAX_DIR_ENTRIES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.dir_byte      (dir_byte),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.files_total   (files_total),
		.entries_used  (entries_used),
		.used_blk_cnt  (used_blk_cnt),
		.free_blk_cnt  (free_blk_cnt),
		.disk_blk_cnt  (disk_blk_cnt),
		.block_bytes   (block_bytes),
		.free_byte_cnt (free_byte_cnt)
	);

endmodule

// File: verif/tb_cpm_allocation_map_stats.sv
// Self-checking testbench for the CP/M directory allocation statistics block.
`timescale 1ns / 100ps

module tb_cpm_allocation_map_stats;
	import cmas_pkg::*;

	localparam int MAP_N          = 4096;
	localparam int SETTLE         = 8;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RAND_BYTES     = 410;
	localparam int IDLE_PCT       = 21;

	// Directory entry layout and special byte values.
	localparam logic [4:0] AT_USER     = 5'd0;
	localparam logic [4:0] AT_EXT_LO   = 5'd12;
	localparam logic [4:0] AT_EXT_HI   = 5'd14;
	localparam logic [4:0] AT_ALLOC    = 5'd16;
	localparam logic [4:0] ENTRY_LAST  = 5'd31;
	localparam logic [7:0] USER_LIMIT  = 8'd31;
	localparam logic [7:0] EXT_HI_BITS = 8'h3F;
	localparam logic [7:0] DELETED     = 8'hE5;
	localparam logic [11:0] WIDE_ABOVE = 12'd255;

	// Register index that selects no register.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [11:0] files_total;
		logic [11:0] entries_used;
		logic [12:0] used_blk_cnt;
		logic [12:0] free_blk_cnt;
		logic [12:0] disk_blk_cnt;
		logic [14:0] block_bytes;
		logic [26:0] free_byte_cnt;
	} dir_summary_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [7:0]            dir_byte = 8'h00;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic                  cfg_ready;
	logic                  done;
	logic [11:0]           files_total;
	logic [11:0]           entries_used;
	logic [12:0]           used_blk_cnt;
	logic [12:0]           free_blk_cnt;
	logic [12:0]           disk_blk_cnt;
	logic [14:0]           block_bytes;
	logic [26:0]           free_byte_cnt;

	cpm_allocation_map_stats uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.dir_byte      (dir_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.done          (done),
		.files_total   (files_total),
		.entries_used  (entries_used),
		.used_blk_cnt  (used_blk_cnt),
		.free_blk_cnt  (free_blk_cnt),
		.disk_blk_cnt  (disk_blk_cnt),
		.block_bytes   (block_bytes),
		.free_byte_cnt (free_byte_cnt)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Bytes waiting to be sent and summaries waiting to come back.
	logic [7:0]   dir_stream_q[$];
	dir_summary_t summary_due_q[$];
	int           summaries_made = 0;
	int           n_fail = 0;
	bit           steady_stream = 1'b0;

	// Register copies as the block should hold them.
	logic [11:0] cur_last_block = LAST_BLOCK_RST;
	logic [2:0]  cur_shift      = BLOCK_SHIFT_RST;
	logic [10:0] cur_last_entry = LAST_DIR_ENTRY_RST;

	// Scan state of the directory walk.
	logic [4:0]       at_byte  = '0;
	logic [10:0]      entry_no = '0;
	logic             in_use   = 1'b0;
	logic             ext_zero = 1'b1;
	logic [7:0]       low_hold = '0;
	logic [11:0]      n_files  = '0;
	logic [11:0]      n_valid  = '0;
	logic [12:0]      n_blocks = '0;
	bit [MAP_N-1:0]   blk_map  = '0;

	// Marks one block number in use, counting it only the first time.
	function automatic void mark_block(input logic [15:0] blk);
		if (blk >= 16'd1 && blk <= {4'h0, cur_last_block} && blk < MAP_N
				&& !blk_map[blk[11:0]]) begin
			blk_map[blk[11:0]] = 1'b1;
			n_blocks = n_blocks + 13'd1;
		end
	endfunction

	// Advances the directory walk by one byte; returns 1 when the summary is due.
	function automatic bit scan_dir_byte(input logic [7:0] b, output dir_summary_t sum);
		logic [12:0] total;
		logic [12:0] spare;
		logic [14:0] bsize;
		sum = '0;
		if (at_byte == AT_USER) begin
			in_use = (b <= USER_LIMIT);
		end else if (at_byte == AT_EXT_LO) begin
			ext_zero = (b == 8'h00);
		end else if (at_byte == AT_EXT_HI) begin
			if ((b & EXT_HI_BITS) != 8'h00) ext_zero = 1'b0;
		end else if (at_byte >= AT_ALLOC) begin
			// Wide disks pair bytes little-endian; the low byte waits at even offsets.
			if (cur_last_block > WIDE_ABOVE) begin
				if (!at_byte[0]) low_hold = b;
				else if (in_use) mark_block({b, low_hold});
			end else if (in_use) begin
				mark_block({8'h00, b});
			end
		end
		if (at_byte != ENTRY_LAST) begin
			at_byte = at_byte + 5'd1;
			return 1'b0;
		end

		// End of an entry.
		at_byte = '0;
		if (in_use) begin
			n_valid = n_valid + 12'd1;
			if (ext_zero) n_files = n_files + 12'd1;
		end
		in_use = 1'b0;
		ext_zero = 1'b1;
		if (entry_no < cur_last_entry) begin
			entry_no = entry_no + 11'd1;
			return 1'b0;
		end

		// End of the directory: report, then start over with an empty map.
		total = {1'b0, cur_last_block} + 13'd1;
		spare = (n_blocks >= total) ? 13'd0 : total - n_blocks;
		bsize = 15'd128 << cur_shift;
		sum.files_total = n_files;
		sum.entries_used = n_valid;
		sum.used_blk_cnt = n_blocks;
		sum.free_blk_cnt = spare;
		sum.disk_blk_cnt = total;
		sum.block_bytes = bsize;
		sum.free_byte_cnt = 27'(spare) * 27'(bsize);
		entry_no = '0;
		low_hold = '0;
		n_files = '0;
		n_valid = '0;
		n_blocks = '0;
		blk_map = '0;
		return 1'b1;
	endfunction

	// Builds a 32-byte entry with random name, s1 and record count bytes.
	function automatic logic [255:0] build_entry(input logic [7:0] user, input logic [7:0] lo,
			input logic [7:0] hi, input logic [127:0] alloc);
		logic [255:0] e;
		int i;
		for (i = 0; i < 16; i++) e[8*i +: 8] = 8'($urandom);
		e[8*AT_USER +: 8] = user;
		e[8*AT_EXT_LO +: 8] = lo;
		e[8*AT_EXT_HI +: 8] = hi;
		e[255:128] = alloc;
		return e;
	endfunction

	// Block numbers mostly around the disk size, some anywhere.
	function automatic logic [127:0] rand_alloc();
		logic [127:0] a;
		int top;
		int i;
		top = int'(cur_last_block) + 2;
		if (cur_last_block > WIDE_ABOVE) begin
			for (i = 0; i < 8; i++)
				a[16*i +: 16] = ($urandom_range(0, 4) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, top));
		end else begin
			if (top > 255) top = 255;
			for (i = 0; i < 16; i++)
				a[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, top));
		end
		return a;
	endfunction

	// Mostly in-use entries, some deleted or with a junk user byte.
	function automatic logic [255:0] rand_entry();
		logic [7:0] user;
		logic [7:0] lo;
		logic [7:0] hi;
		case ($urandom_range(0, 19))
			0, 1: user = DELETED;
			2, 3, 4: user = 8'($urandom);
			default: user = 8'($urandom_range(0, 31));
		endcase
		lo = ($urandom_range(0, 9) < 6) ? 8'h00 : 8'($urandom);
		hi = $urandom_range(0, 1) ? (8'($urandom) & 8'hC0) : 8'($urandom);
		return build_entry(user, lo, hi, rand_alloc());
	endfunction

	task automatic push_span(input logic [255:0] e, input int first, input int last);
		int i;
		for (i = first; i <= last; i++) dir_stream_q.push_back(e[8*i +: 8]);
	endtask

	task automatic push_entry(input logic [255:0] e);
		push_span(e, 0, 31);
	endtask

	// Waits until every byte is taken and every summary has come back.
	task automatic drain();
		while (dir_stream_q.size() != 0 || summary_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write, after a short random gap.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [11:0] val);
		repeat ($urandom_range(0, 2)) @(posedge clk);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LAST_BLOCK: cur_last_block = val;
			CFG_BLOCK_SHIFT: cur_shift = val[2:0];
			CFG_LAST_DIR_ENTRY: cur_last_entry = val[10:0];
			default: ;
		endcase
	endtask

	// Byte driver: holds a request until taken, then offers the next one or idles.
	always @(posedge clk) begin : drive_bytes
		dir_summary_t sum;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				if (scan_dir_byte(dir_byte, sum)) begin
					summary_due_q.push_back(sum);
					summaries_made++;
				end
				void'(dir_stream_q.pop_front());
			end
			if (!(start && busy)) begin
				if (dir_stream_q.size() != 0
						&& (steady_stream || $urandom_range(0, 99) >= IDLE_PCT)) begin
					start <= 1'b1;
					dir_byte <= dir_stream_q[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [26:0] want,
			input logic [26:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endtask

	// Summary checker: every strobe must match the oldest summary due.
	always @(posedge clk) begin : check_summary
		dir_summary_t want;
		if (arst_n && done) begin
			if (summary_due_q.size() == 0) begin
				$error("summary strobe with no summary due");
				n_fail++;
			end else begin
				want = summary_due_q.pop_front();
				check_field("files_total", 27'(want.files_total), 27'(files_total));
				check_field("entries_used", 27'(want.entries_used), 27'(entries_used));
				check_field("used_blk_cnt", 27'(want.used_blk_cnt), 27'(used_blk_cnt));
				check_field("free_blk_cnt", 27'(want.free_blk_cnt), 27'(free_blk_cnt));
				check_field("disk_blk_cnt", 27'(want.disk_blk_cnt), 27'(disk_blk_cnt));
				check_field("block_bytes", 27'(want.block_bytes), 27'(block_bytes));
				check_field("free_byte_cnt", want.free_byte_cnt, free_byte_cnt);
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		logic [255:0] ent;
		logic [127:0] wide;
		logic [11:0]  lb;
		int i;
		int j;
		int n;
		int rand_bytes;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// One entry per directory on a tiny disk; upper data bits must be ignored.
		write_reg(CFG_LAST_DIR_ENTRY, 12'h800);
		write_reg(CFG_LAST_BLOCK, 12'd20);
		write_reg(CFG_BLOCK_SHIFT, 12'hFF8);
		write_reg(CFG_SPARE, 12'hA5A);
		// Block zero, first, last, one past last and a repeat; extent high bits 6-7 only.
		push_entry(build_entry(8'h00, 8'h00, 8'hC0, 128'h00000000_00000000_FF050501_15140100));
		push_entry(build_entry(USER_LIMIT, 8'h01, 8'h00, rand_alloc()));
		push_entry(build_entry(8'd32, 8'h00, 8'h00, 128'h100F0E0D_0C0B0A09_08070605_04030201));
		push_entry(build_entry(DELETED, 8'h00, 8'h00, rand_alloc()));
		push_entry(build_entry(8'h00, 8'h00, 8'h01, rand_alloc()));
		push_entry(build_entry(8'hFF, 8'hFF, 8'hFF, {16{8'hFF}}));
		drain();

		// Largest disk and block size: an empty directory gives the most free bytes.
		write_reg(CFG_LAST_BLOCK, 12'd4095);
		write_reg(CFG_BLOCK_SHIFT, 12'd7);
		push_entry(build_entry(DELETED, 8'h00, 8'h00, rand_alloc()));
		push_entry(build_entry(8'h00, 8'h00, 8'h00,
			128'h0001_00FF_0100_FFFF_1000_0FFF_0001_0000));
		drain();

		// Single-block disk: nothing can be marked.
		write_reg(CFG_LAST_BLOCK, 12'd0);
		push_entry(build_entry(8'h05, 8'h00, 8'h00, 128'h00000000_00000000_00000000_00000100));
		drain();

		// Shrink the disk halfway through a directory: used blocks exceed the total.
		write_reg(CFG_LAST_BLOCK, 12'd4095);
		write_reg(CFG_LAST_DIR_ENTRY, 12'd1);
		write_reg(CFG_BLOCK_SHIFT, 12'd2);
		push_entry(build_entry(8'h01, 8'h00, 8'h00, rand_alloc()));
		ent = build_entry(8'h02, 8'h00, 8'h00, rand_alloc());
		push_span(ent, 0, 16);
		drain();
		write_reg(CFG_LAST_BLOCK, 12'd3);
		push_span(ent, 17, 31);
		drain();

		// Switch to wide block numbers at an odd offset: the stale low byte is paired.
		write_reg(CFG_LAST_BLOCK, 12'd200);
		write_reg(CFG_LAST_DIR_ENTRY, 12'd0);
		ent = build_entry(8'h00, 8'h00, 8'h00, rand_alloc());
		push_span(ent, 0, 16);
		drain();
		write_reg(CFG_LAST_BLOCK, 12'd4095);
		push_span(ent, 17, 31);
		drain();

		// A short directory of files, sent back to back with wide block numbers.
		write_reg(CFG_BLOCK_SHIFT, 12'd1);
		write_reg(CFG_LAST_DIR_ENTRY, 12'd7);
		steady_stream = 1'b1;
		for (i = 0; i < 8; i++) begin
			for (j = 0; j < 8; j++) wide[16*j +: 16] = 16'($urandom_range(1, 4095));
			push_entry(build_entry(8'($urandom_range(0, 31)), 8'h00, 8'($urandom) & 8'hC0,
				wide));
		end
		drain();
		steady_stream = 1'b0;

		// Random phases: new settings, a few entries, sometimes a partial one.
		rand_bytes = 0;
		while (rand_bytes < RAND_BYTES) begin
			drain();
			case ($urandom_range(0, 7))
				0: lb = 12'd0;
				1: lb = 12'd255;
				2: lb = 12'd256;
				3: lb = 12'd4095;
				4, 5: lb = 12'($urandom_range(1, 254));
				default: lb = 12'($urandom_range(257, 4094));
			endcase
			write_reg(CFG_LAST_BLOCK, lb);
			if ($urandom_range(0, 1))
				write_reg(CFG_BLOCK_SHIFT, {9'($urandom), 3'($urandom_range(0, 7))});
			if ($urandom_range(0, 1))
				write_reg(CFG_LAST_DIR_ENTRY, {1'($urandom),
					($urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(1, 3)))});
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) push_entry(rand_entry());
			rand_bytes += 32 * n;
			if ($urandom_range(0, 3) == 0) begin
				j = $urandom_range(0, 30);
				push_span(rand_entry(), 0, j);
				rand_bytes += j + 1;
			end
		end

		drain();
		repeat (2 * SETTLE) @(posedge clk);
		if (n_fail == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
